/* design/sia_pkg.sv */
`default_nettype none

package sia_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    // capacity after reset, limited to the slot count
    localparam int CAP_RESET_RAW = 1024;
    localparam int CAP_RESET     = (CAP_RESET_RAW > MAX_SLOTS) ? MAX_SLOTS : CAP_RESET_RAW;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_QUERY   = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

    typedef struct packed {
        func_t             func;
        logic [SLOT_W-1:0] idx;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0]  cap;
        logic [CNT_W-1:0]  bump;
        logic [CNT_W-1:0]  count;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  bump;
        logic [CNT_W-1:0]  count;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
        logic              map_we;
        logic [SLOT_W-1:0] map_addr;
        logic              map_bit;
        logic              fifo_we;
        logic [SLOT_W-1:0] fifo_addr;
        logic [SLOT_W-1:0] fifo_data;
    } update_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted;
        status_t           status;
        logic              in_use;
    } result_t;

endpackage

`default_nettype wire

/* design/sia_ram.sv */
`default_nettype none

module sia_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/sia_decide.sv */
`default_nettype none

module sia_decide (
    input  sia_pkg::req_t                  req,
    input  sia_pkg::state_t                st,
    input  logic                           map_bit,
    input  logic [sia_pkg::SLOT_W-1:0]     fifo_data,
    output sia_pkg::result_t               res,
    output sia_pkg::update_t               upd
);

    import sia_pkg::*;

    logic              in_range;
    logic [SLOT_W-1:0] head_inc;
    logic [SLOT_W-1:0] tail_inc;

    assign in_range = {1'b0, req.idx} < st.cap;
    assign head_inc = (st.head == SLOT_W'(MAX_SLOTS - 1)) ? '0 : st.head + SLOT_W'(1);
    assign tail_inc = (st.tail == SLOT_W'(MAX_SLOTS - 1)) ? '0 : st.tail + SLOT_W'(1);

    always_comb
    begin
        res.granted   = '0;
        res.status    = ST_OK;
        res.in_use    = 1'b0;
        upd.bump      = st.bump;
        upd.count     = st.count;
        upd.head      = st.head;
        upd.tail      = st.tail;
        upd.map_we    = 1'b0;
        upd.map_addr  = req.idx;
        upd.map_bit   = 1'b0;
        upd.fifo_we   = 1'b0;
        upd.fifo_addr = st.tail;
        upd.fifo_data = req.idx;

        case (req.func)
            FUNC_ALLOC:
            begin
                if (st.count != '0)
                begin
                    // recycled slots go out first
                    res.granted  = fifo_data;
                    upd.head     = head_inc;
                    upd.count    = st.count - CNT_W'(1);
                    upd.map_we   = 1'b1;
                    upd.map_addr = fifo_data;
                    upd.map_bit  = 1'b1;
                end
                else if (st.bump < st.cap)
                begin
                    res.granted  = st.bump[SLOT_W-1:0];
                    upd.bump     = st.bump + CNT_W'(1);
                    upd.map_we   = 1'b1;
                    upd.map_addr = st.bump[SLOT_W-1:0];
                    upd.map_bit  = 1'b1;
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            FUNC_RELEASE:
            begin
                if (!in_range)
                begin
                    res.status = ST_RANGE;
                end
                else if (!map_bit)
                begin
                    res.status = ST_NOT_ALLOC;
                end
                else
                begin
                    upd.map_we = 1'b1;
                    if (st.count < CNT_W'(MAX_SLOTS))
                    begin
                        upd.fifo_we = 1'b1;
                        upd.tail    = tail_inc;
                        upd.count   = st.count + CNT_W'(1);
                    end
                end
            end
            FUNC_QUERY:
            begin
                if (!in_range)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    res.in_use = map_bit;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/sia_result_reg.sv */
`default_nettype none

module sia_result_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  sia_pkg::result_t               res_in,
    output logic                           ready,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [sia_pkg::SLOT_W-1:0]     granted_index,
    output logic [sia_pkg::STATUS_W-1:0]   status,
    output logic                           slot_in_use
);

    import sia_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // a held result may leave in the same cycle a new one loads
    assign ready = !valid_reg || !rsp_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign rsp_valid     = valid_reg;
    assign granted_index = res_reg.granted;
    assign status        = res_reg.status;
    assign slot_in_use   = res_reg.in_use;

endmodule

`default_nettype wire

/* design/slot_index_allocator_core.sv */
`default_nettype none

// Slot index allocator. Takes one allocate, release or query request per clock unless req_stall
// is high, and returns exactly one result per request, through the request register and then
// the result register; a stalled result does not block the next request from entering. The
// allocated bitmap and the queue of released indices are 1024-entry RAMs with registered
// read, read at the cycle a request is accepted and written when it reaches the result
// register, with bypass of the last write. A capacity write takes effect on the next clock
// with no clearing pass: bitmap entries at or above the bump pointer read as free. Write the
// capacity only while no request is in flight; zero is ignored and values above 1024 are
// limited to 1024.
module slot_index_allocator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sia_pkg::CNT_W-1:0]      cfg_wr_data,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [sia_pkg::FUNC_W-1:0]     func,
    input  logic [sia_pkg::SLOT_W-1:0]     slot_index,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [sia_pkg::SLOT_W-1:0]     granted_index,
    output logic [sia_pkg::STATUS_W-1:0]   status,
    output logic                           slot_in_use
);

    import sia_pkg::*;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    req_t              s1_req_reg;
    logic              req_accept;
    logic              s1_fire;
    logic              out_ready;

    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  bump_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SLOT_W-1:0] head_reg;
    logic [SLOT_W-1:0] tail_reg;

    logic              map_fwd_vld_reg;
    logic [SLOT_W-1:0] map_fwd_addr_reg;
    logic              map_fwd_bit_reg;
    logic              fifo_fwd_vld_reg;
    logic [SLOT_W-1:0] fifo_fwd_addr_reg;
    logic [SLOT_W-1:0] fifo_fwd_data_reg;

    logic              cfg_take;
    logic [CNT_W-1:0]  cfg_cap;
    logic              map_rdata;
    logic [SLOT_W-1:0] fifo_rdata;
    logic              map_bit;
    logic [SLOT_W-1:0] fifo_data;
    logic [SLOT_W-1:0] fifo_raddr;
    state_t            st;
    update_t           upd;
    result_t           res;

    assign s1_fire    = s1_valid_reg && out_ready;
    assign req_stall  = s1_valid_reg && !s1_fire;
    assign req_accept = req_valid && !req_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_req_reg.func <= func_t'(func);
            s1_req_reg.idx  <= slot_index;
        end
    end

    assign cfg_take = cfg_wr_en && (cfg_wr_data != '0);
    assign cfg_cap  = (cfg_wr_data > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cfg_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg          <= CNT_W'(CAP_RESET);
            bump_reg         <= '0;
            count_reg        <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            map_fwd_vld_reg  <= 1'b0;
            fifo_fwd_vld_reg <= 1'b0;
        end
        else if (cfg_take)
        begin
            cap_reg          <= cfg_cap;
            bump_reg         <= '0;
            count_reg        <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            map_fwd_vld_reg  <= 1'b0;
            fifo_fwd_vld_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            bump_reg  <= upd.bump;
            count_reg <= upd.count;
            head_reg  <= upd.head;
            tail_reg  <= upd.tail;
            if (upd.map_we)
            begin
                map_fwd_vld_reg <= 1'b1;
            end
            if (upd.fifo_we)
            begin
                fifo_fwd_vld_reg <= 1'b1;
            end
        end
    end

    // last write to each ram, covers a read taken in the same cycle as the write
    always_ff @(posedge clk)
    begin
        if (s1_fire && upd.map_we)
        begin
            map_fwd_addr_reg <= upd.map_addr;
            map_fwd_bit_reg  <= upd.map_bit;
        end
        if (s1_fire && upd.fifo_we)
        begin
            fifo_fwd_addr_reg <= upd.fifo_addr;
            fifo_fwd_data_reg <= upd.fifo_data;
        end
    end

    // head moves in the same cycle the next request reads the queue
    assign fifo_raddr = s1_fire ? upd.head : head_reg;

    sia_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SLOTS)
    ) u_map_ram (
        .clk   (clk),
        .we    (s1_fire && upd.map_we),
        .waddr (upd.map_addr),
        .wdata (upd.map_bit),
        .re    (req_accept),
        .raddr (slot_index),
        .rdata (map_rdata)
    );

    sia_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (s1_fire && upd.fifo_we),
        .waddr (upd.fifo_addr),
        .wdata (upd.fifo_data),
        .re    (req_accept),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    // slots at or above the bump pointer were never handed out since the last clear
    always_comb
    begin
        map_bit = map_rdata;
        if (map_fwd_vld_reg && (map_fwd_addr_reg == s1_req_reg.idx))
        begin
            map_bit = map_fwd_bit_reg;
        end
        if ({1'b0, s1_req_reg.idx} >= bump_reg)
        begin
            map_bit = 1'b0;
        end
    end

    assign fifo_data = (fifo_fwd_vld_reg && (fifo_fwd_addr_reg == head_reg)) ?
                       fifo_fwd_data_reg : fifo_rdata;

    assign st.cap   = cap_reg;
    assign st.bump  = bump_reg;
    assign st.count = count_reg;
    assign st.head  = head_reg;
    assign st.tail  = tail_reg;

    sia_decide u_decide (
        .req       (s1_req_reg),
        .st        (st),
        .map_bit   (map_bit),
        .fifo_data (fifo_data),
        .res       (res),
        .upd       (upd)
    );

    sia_result_reg u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (s1_fire),
        .res_in        (res),
        .ready         (out_ready),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .granted_index (granted_index),
        .status        (status),
        .slot_in_use   (slot_in_use)
    );

endmodule

`default_nettype wire

/* design/sia_checker.sv */
`default_nettype none

module sia_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  logic [sia_pkg::SLOT_W-1:0]     granted_index,
    input  logic [sia_pkg::STATUS_W-1:0]   status,
    input  logic                           slot_in_use
);

    import sia_pkg::*;

    logic       req_take;
    logic       rsp_take;
    logic [2:0] occ_reg;
    logic [2:0] occ_next;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    // requests accepted whose result has not been taken yet
    always_comb
    begin
        occ_next = occ_reg;
        if (req_take && !rsp_take)
        begin
            occ_next = occ_reg + 3'd1;
        end
        else if (!req_take && rsp_take)
        begin
            occ_next = occ_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(granted_index) && $stable(status)
                                   && $stable(slot_in_use))
        else $error("result changed while stalled");

    a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> granted_index == '0)
        else $error("index granted with a failing status");

    a_in_use_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && slot_in_use |-> (status == ST_OK) && (granted_index == '0))
        else $error("slot in use reported with other result fields set");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == 3'd0 |-> !req_stall && !rsp_valid)
        else $error("stall or result with nothing in flight");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 3'd2)
        else $error("more than two requests in flight");

endmodule

bind slot_index_allocator_core sia_checker u_sia_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .granted_index (granted_index),
    .status        (status),
    .slot_in_use   (slot_in_use)
);

`default_nettype wire
